// ----- rtl/npc_pkg.sv -----
// ----------------------------------------------------------------------------
// npc_pkg
// Shared sizes, codes and types of the nearest palette color core.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int PALETTE_DEPTH = 16;
  localparam int CHANNEL_BITS  = 16;

  localparam int IDX_BITS  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int SIZE_BITS = 5;
  localparam int SQ_BITS   = 2 * CHANNEL_BITS;
  localparam int W_BITS    = 7;
  localparam int DIST_BITS = SQ_BITS + W_BITS;

  localparam logic [W_BITS-1:0] W_RED   = W_BITS'(30);
  localparam logic [W_BITS-1:0] W_GREEN = W_BITS'(59);
  localparam logic [W_BITS-1:0] W_BLUE  = W_BITS'(11);
  localparam logic [W_BITS-1:0] W_UNIT  = W_BITS'(1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_DISTANCE_MODE = 1'b0;
  localparam logic REG_PALETTE_SIZE  = 1'b1;

  localparam logic MODE_PLAIN    = 1'b0;
  localparam logic MODE_WEIGHTED = 1'b1;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [IDX_BITS-1:0] idx;
    rgb_t                color;
  } tag_t;

endpackage

// ----- rtl/nearest_palette_color_core.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_core
// Palette memory with a nearest color search over its entries in use.
// ----------------------------------------------------------------------------
// A load beat (tuser low) writes one palette entry in the cycle it is
// accepted. A query beat (tuser high) reads the entries in use from the
// palette memory, one per cycle, through a four-stage distance pipeline;
// the entries in use are the first palette_size ones, clamped to the
// palette depth. A query against an empty palette returns found low with
// zero color. The input takes a new beat once the previous query has
// handed its result to the output register, which holds it until taken.
module nearest_palette_color_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // entry_index[3:0], in_red[19:4], in_green[35:20], in_blue[51:36]
  input  logic [0:0]  s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // nearest_index[3:0], out_red[19:4], out_green[35:20], out_blue[51:36]
  output logic [0:0]  m_tuser,   // found[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  import npc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT, S_DONE} state_t;

  state_t                state;
  logic                  distance_mode;
  logic [SIZE_BITS-1:0]  palette_size;
  logic [SIZE_BITS-1:0]  count;
  logic [IDX_BITS-1:0]   rd_addr;
  logic [IDX_BITS-1:0]   last_addr;
  rgb_t                  query;
  rgb_t                  in_color;
  logic [3:0]            in_index;
  logic                  in_accept;
  logic                  wr_en;
  rgb_t                  palette_mem [PALETTE_DEPTH];
  rgb_t                  rdata;
  logic                  rd_valid;
  logic                  rd_last;
  logic [IDX_BITS-1:0]   rd_idx;
  tag_t                  dist_in;
  tag_t                  out_tag;
  logic [DIST_BITS-1:0]  out_dist;
  logic                  take;
  logic [DIST_BITS-1:0]  best_dist;
  logic [IDX_BITS-1:0]   best_idx;
  rgb_t                  best_color;
  logic                  best_found;
  logic                  res_found;
  logic [IDX_BITS-1:0]   res_idx;
  rgb_t                  res_color;

  assign in_index       = s_tdata[3:0];
  assign in_color.red   = s_tdata[4 +: CHANNEL_BITS];
  assign in_color.green = s_tdata[20 +: CHANNEL_BITS];
  assign in_color.blue  = s_tdata[36 +: CHANNEL_BITS];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign wr_en     = in_accept && (s_tuser[0] == OP_LOAD) &&
                     ({1'b0, in_index} < 5'(PALETTE_DEPTH));
  assign count     = (palette_size > SIZE_BITS'(PALETTE_DEPTH)) ?
                     SIZE_BITS'(PALETTE_DEPTH) : palette_size;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_mem[in_index[IDX_BITS-1:0]] <= in_color;
    end
    rdata <= palette_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mode <= MODE_PLAIN;
      palette_size  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DISTANCE_MODE: distance_mode <= cfg_data[0];
        REG_PALETTE_SIZE:  palette_size  <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_comb begin
    dist_in.valid = rd_valid;
    dist_in.last  = rd_last;
    dist_in.idx   = rd_idx;
    dist_in.color = rdata;
  end

  npc_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .mode     (distance_mode),
    .query    (query),
    .in_tag   (dist_in),
    .out_tag  (out_tag),
    .out_dist (out_dist)
  );

  assign take = out_tag.valid && ((out_tag.idx == '0) || (out_dist < best_dist));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_valid <= (state == S_SCAN);
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept && (s_tuser[0] == OP_QUERY)) begin
            if (count == '0) begin
              best_found <= 1'b0;
              state      <= S_DONE;
            end else begin
              best_found <= 1'b1;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_addr <= rd_addr + 1'b1;
          if (rd_addr == last_addr) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_tag.valid && out_tag.last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            res_found <= best_found;
            res_idx   <= best_found ? best_idx : '0;
            res_color <= best_found ? best_color : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (in_accept) begin
      query     <= in_color;
      rd_addr   <= '0;
      last_addr <= IDX_BITS'(count - 1'b1);
    end
    rd_last <= (rd_addr == last_addr);
    rd_idx  <= rd_addr;
    if (take) begin
      best_dist  <= out_dist;
      best_idx   <= out_tag.idx;
      best_color <= out_tag.color;
    end
  end

  assign m_tdata = {4'b0, res_color.blue, res_color.green, res_color.red,
                    4'(res_idx)};
  assign m_tuser = res_found;

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("result without a match carries nonzero data");

  a_pipe_busy: assert property (@(posedge clk) disable iff (rst)
    out_tag.valid |-> ((state == S_SCAN) || (state == S_WAIT)))
    else $error("distance pipeline active outside a query scan");

  a_index_in_use: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> ({1'b0, m_tdata[3:0]} < count))
    else $error("nearest index beyond the palette in use");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, rd_addr} < count))
    else $error("palette read beyond the entries in use");

endmodule

// ----- rtl/npc_dist.sv -----
// ----------------------------------------------------------------------------
// npc_dist
// Four-stage pipeline that computes the plain or weighted squared distance
// between one palette entry and the query color, carrying the entry along.
// ----------------------------------------------------------------------------
module npc_dist (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      mode,
  input  npc_pkg::rgb_t             query,
  input  npc_pkg::tag_t             in_tag,
  output npc_pkg::tag_t             out_tag,
  output logic [npc_pkg::DIST_BITS-1:0] out_dist
);
  import npc_pkg::*;

  tag_t tag1, tag2, tag3, tag4;
  logic [CHANNEL_BITS-1:0] dr, dg, db;
  logic [SQ_BITS-1:0]      sr, sg, sb;
  logic [DIST_BITS-1:0]    pr, pg, pb;
  logic [DIST_BITS-1:0]    dist_sum;

  function automatic logic [CHANNEL_BITS-1:0] abs_diff(
    input logic [CHANNEL_BITS-1:0] a,
    input logic [CHANNEL_BITS-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
      tag3.valid <= 1'b0;
      tag4.valid <= 1'b0;
    end else begin
      tag1.valid <= in_tag.valid;
      tag2.valid <= tag1.valid;
      tag3.valid <= tag2.valid;
      tag4.valid <= tag3.valid;
    end
    tag1.last  <= in_tag.last;
    tag1.idx   <= in_tag.idx;
    tag1.color <= in_tag.color;
    tag2.last  <= tag1.last;
    tag2.idx   <= tag1.idx;
    tag2.color <= tag1.color;
    tag3.last  <= tag2.last;
    tag3.idx   <= tag2.idx;
    tag3.color <= tag2.color;
    tag4.last  <= tag3.last;
    tag4.idx   <= tag3.idx;
    tag4.color <= tag3.color;

    dr <= abs_diff(in_tag.color.red, query.red);
    dg <= abs_diff(in_tag.color.green, query.green);
    db <= abs_diff(in_tag.color.blue, query.blue);

    sr <= SQ_BITS'(dr) * SQ_BITS'(dr);
    sg <= SQ_BITS'(dg) * SQ_BITS'(dg);
    sb <= SQ_BITS'(db) * SQ_BITS'(db);

    pr <= DIST_BITS'(sr) * DIST_BITS'((mode == MODE_WEIGHTED) ? W_RED : W_UNIT);
    pg <= DIST_BITS'(sg) * DIST_BITS'((mode == MODE_WEIGHTED) ? W_GREEN : W_UNIT);
    pb <= DIST_BITS'(sb) * DIST_BITS'((mode == MODE_WEIGHTED) ? W_BLUE : W_UNIT);

    dist_sum <= pr + pg + pb;
  end

  assign out_tag  = tag4;
  assign out_dist = dist_sum;

endmodule

// ----- sim/nearest_palette_color_checker.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_checker
// Watches the configuration, input and output channels of the nearest
// palette color core. It keeps its own palette and register copies, works
// out the nearest entry for each accepted query beat and compares every
// result beat with the oldest outstanding answer, field by field.
// ----------------------------------------------------------------------------
module nearest_palette_color_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // entry_index[3:0], in_red[19:4], in_green[35:20], in_blue[51:36]
  input  logic [0:0]  s_tuser,   // operation[0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // nearest_index[3:0], out_red[19:4], out_green[35:20], out_blue[51:36]
  input  logic [0:0]  m_tuser,   // found[0]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output int          mismatches,
  output int          pending
);
  import npc_pkg::*;

  typedef struct packed {
    logic                found;
    logic [IDX_BITS-1:0] idx;
    rgb_t                color;
  } match_t;

  rgb_t                 palette [PALETTE_DEPTH];
  logic                 distance_mode;
  logic [SIZE_BITS-1:0] palette_size;
  match_t               awaited_matches [$];
  int                   fail_count;

  function automatic longint unsigned channel_sq(logic [CHANNEL_BITS-1:0] a,
                                                 logic [CHANNEL_BITS-1:0] b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic match_t search_nearest(rgb_t q);
    match_t          best;
    longint unsigned dr;
    longint unsigned dg;
    longint unsigned db;
    longint unsigned dist_sum;
    longint unsigned best_dist;
    int              used;
    best = '0;
    best_dist = 0;
    used = (palette_size > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(palette_size);
    for (int i = 0; i < used; i++) begin
      dr = channel_sq(palette[i].red, q.red);
      dg = channel_sq(palette[i].green, q.green);
      db = channel_sq(palette[i].blue, q.blue);
      if (distance_mode == MODE_WEIGHTED) begin
        dist_sum = W_RED * dr + W_GREEN * dg + W_BLUE * db;
      end else begin
        dist_sum = dr + dg + db;
      end
      if (!best.found || dist_sum < best_dist) begin
        best.found = 1'b1;
        best.idx   = IDX_BITS'(i);
        best.color = palette[i];
        best_dist  = dist_sum;
      end
    end
    return best;
  endfunction

  task automatic flag_result(input string what, input match_t want, input match_t got);
    if (fail_count < 10) begin
      $display("%s: expected found=%0b index=%0d rgb=%h/%h/%h, %s%0b index=%0d rgb=%h/%h/%h",
               what, want.found, want.idx, want.color.red, want.color.green,
               want.color.blue, "got found=", got.found, got.idx, got.color.red,
               got.color.green, got.color.blue);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    match_t got;
    match_t want;
    rgb_t   query;
    if (rst) begin
      awaited_matches.delete();
      distance_mode = MODE_PLAIN;
      palette_size  = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DISTANCE_MODE) begin
          distance_mode = cfg_data[0];
        end else begin
          palette_size = cfg_data;
        end
      end
      if (m_tvalid && m_tready) begin
        got.found = m_tuser[0];
        got.idx   = m_tdata[3:0];
        got.color = {m_tdata[51:36], m_tdata[35:20], m_tdata[19:4]};
        if (awaited_matches.size() == 0) begin
          flag_result("result beat with nothing outstanding", '0, got);
        end else begin
          want = awaited_matches.pop_front();
          if (got.found !== want.found || got.idx !== want.idx ||
              got.color.red !== want.color.red || got.color.green !== want.color.green ||
              got.color.blue !== want.color.blue) begin
            flag_result("result mismatch", want, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        query = {s_tdata[51:36], s_tdata[35:20], s_tdata[19:4]};
        if (s_tuser[0] == OP_LOAD) begin
          palette[s_tdata[3:0]] = query;
        end else begin
          awaited_matches.push_back(search_nearest(query));
        end
      end
    end
    mismatches <= fail_count;
    pending    <= awaited_matches.size();
  end

endmodule

// ----- sim/nearest_palette_color_core_test.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_core_test
// Drives the nearest palette color core with a short directed sequence and
// then with phases of random loads and queries under several distance modes
// and palette sizes, with bursty input and a stalling output side. The
// checker beside the core predicts every result; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module nearest_palette_color_core_test;
  import npc_pkg::*;

  localparam int LONG_STALL    = 400;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 110;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [4:0]  cfg_data;

  int   mismatches;
  int   pending;
  int   cycles;
  int   burst_left;
  int   stalls_requested;
  int   stalls_served;
  rgb_t palette_shadow [PALETTE_DEPTH];

  nearest_palette_color_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nearest_palette_color_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The output side alternates between stall patterns and serves a long
  // hold-off whenever one is requested.
  initial begin : receiver
    int shape;
    int span;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stalls_served < stalls_requested) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stalls_served++;
      end else begin
        shape = $urandom_range(0, 3);
        span  = $urandom_range(8, 60);
        repeat (span) begin
          case (shape)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic rgb_t make_color(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
                                      logic [CHANNEL_BITS-1:0] b);
    rgb_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    return c;
  endfunction

  function automatic rgb_t random_color();
    return make_color(CHANNEL_BITS'($urandom_range(0, 65535)),
                      CHANNEL_BITS'($urandom_range(0, 65535)),
                      CHANNEL_BITS'($urandom_range(0, 65535)));
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] nudge(logic [CHANNEL_BITS-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 8)) - 4;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return CHANNEL_BITS'(t);
  endfunction

  // Offers one beat and returns at the edge it is taken; between bursts the
  // valid line may drop for a random gap.
  task automatic send_beat(input logic op, input logic [IDX_BITS-1:0] slot, input rgb_t c);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, c.blue, c.green, c.red, slot};
    if (op == OP_LOAD) palette_shadow[slot] = c;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [4:0] size);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DISTANCE_MODE;
    cfg_data  <= {4'b0000, mode};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_PALETTE_SIZE;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    rgb_t                c;
    rgb_t                base;
    int                  pick;
    logic [IDX_BITS-1:0] slot;
    slot = IDX_BITS'($urandom_range(0, 15));
    base = palette_shadow[IDX_BITS'($urandom_range(0, PALETTE_DEPTH - 1))];
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c = ($urandom_range(0, 4) == 0) ? base : random_color();
      send_beat(OP_LOAD, slot, c);
    end else begin
      if (pick < 60) begin
        c = make_color(nudge(base.red), nudge(base.green), nudge(base.blue));
      end else if (pick < 70) begin
        c = base;
      end else if (pick < 90) begin
        c = random_color();
      end else begin
        c = make_color({CHANNEL_BITS{1'($urandom_range(0, 1))}},
                       {CHANNEL_BITS{1'($urandom_range(0, 1))}},
                       {CHANNEL_BITS{1'($urandom_range(0, 1))}});
      end
      send_beat(OP_QUERY, slot, c);
    end
  endtask

  initial begin
    rgb_t c;
    int   preset_size [6];
    logic mode;
    logic [4:0] size;
    preset_size = '{31, 0, 1, 17, 16, 2};
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_LOAD;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DISTANCE_MODE;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Queries against the empty palette left by reset.
    send_beat(OP_QUERY, 4'hF, make_color(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(OP_QUERY, 4'h0, make_color(16'h0000, 16'h0000, 16'h0000));

    // Slots one and two hold the same color so that a query on it ties.
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      case (i)
        0: c = make_color(16'h0000, 16'h0000, 16'h0000);
        1, 2: c = make_color(16'h1234, 16'h5678, 16'h9ABC);
        3: c = make_color(16'hFFFF, 16'h0000, 16'h0000);
        4: c = make_color(16'h0000, 16'hFFFF, 16'h0000);
        5: c = make_color(16'h0000, 16'h0000, 16'hFFFF);
        15: c = make_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: c = random_color();
      endcase
      send_beat(OP_LOAD, IDX_BITS'(i), c);
    end

    drain();
    set_config(MODE_PLAIN, 5'd16);
    send_beat(OP_QUERY, 4'h0, make_color(16'h0000, 16'h0000, 16'h0000));
    send_beat(OP_QUERY, 4'h3, make_color(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(OP_QUERY, 4'hA, make_color(16'h1234, 16'h5678, 16'h9ABC));
    send_beat(OP_QUERY, 4'h5, make_color(16'hFFF0, 16'h0010, 16'h0000));
    send_beat(OP_QUERY, 4'hC, make_color(16'h8000, 16'h8000, 16'h8000));
    drain();
    set_config(MODE_WEIGHTED, 5'd16);
    send_beat(OP_QUERY, 4'h1, make_color(16'h1234, 16'h5678, 16'h9ABC));
    send_beat(OP_QUERY, 4'h6, make_color(16'h8000, 16'h4000, 16'hC000));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      mode = (ph % 2 == 0) ? MODE_WEIGHTED : MODE_PLAIN;
      size = (ph < 6) ? 5'(preset_size[ph]) : 5'($urandom_range(0, 31));
      if (ph >= 6) mode = 1'($urandom_range(0, 1));
      set_config(mode, size);
      if (ph == 2 || ph == 7) stalls_requested++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) drain();
        random_item();
      end
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/npc_pkg.sv
rtl/npc_dist.sv
rtl/nearest_palette_color_core.sv
sim/nearest_palette_color_checker.sv
sim/nearest_palette_color_core_test.sv
